@@ sv/ipow_pkg.sv @@
// ============================================================================
// ipow_pkg: shared types and constants of the integer power unit
// Holds the control word that travels down the pipeline beside the data.
// ============================================================================
package ipow_pkg;

    // Widths of the request and result fields.
    localparam int BASE_W  = 32;
    localparam int EXP_W   = 8;
    localparam int POWER_W = 64;
    localparam int HALF_W  = POWER_W / 2;

    // Number of square-and-multiply steps, one per low exponent bit.
    localparam int STEPS = 6;

    // Exponents at or above this limit take the fixed large-exponent rule.
    localparam logic [EXP_W-1:0] EXP_LIMIT = 8'd63;

    localparam logic [POWER_W-1:0] POWER_ONE  = 64'd1;
    localparam logic [POWER_W-1:0] POWER_MONE = {POWER_W{1'b1}};
    localparam logic [POWER_W-1:0] POWER_ZERO = '0;

    // Control word carried along with each request.
    typedef struct packed {
        logic [EXP_W-1:0] exponent;
        logic             big;        // exponent at or above the limit
        logic             base_one;   // base equals +1
        logic             base_mone;  // base equals -1
    } ipow_ctrl_t;

endpackage

@@ sv/ipow_step.sv @@
// ============================================================================
// ipow_step: one square-and-multiply step
// Two register stages: 32x32 partial products, then the 64-bit sums.
// Products wrap modulo 2^64, so only the low halves of cross terms are kept.
// ============================================================================
module ipow_step #(
    parameter int unsigned BIT       = 0,
    parameter bit          SQUARE_EN = 1'b1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  ipow_pkg::ipow_ctrl_t        in_ctrl,
    input  logic [ipow_pkg::POWER_W-1:0] in_result,
    input  logic [ipow_pkg::POWER_W-1:0] in_square,
    output logic                        out_valid,
    input  logic                        out_ready,
    output ipow_pkg::ipow_ctrl_t        out_ctrl,
    output logic [ipow_pkg::POWER_W-1:0] out_result,
    output logic [ipow_pkg::POWER_W-1:0] out_square
);
    import ipow_pkg::*;

    // Stage A: partial products.
    logic                va_reg;
    ipow_ctrl_t          ctrl_a_reg;
    logic [POWER_W-1:0]  res_a_reg;
    logic [POWER_W-1:0]  rs_ll_reg;
    logic [HALF_W-1:0]   rs_lh_reg;
    logic [HALF_W-1:0]   rs_hl_reg;
    logic [POWER_W-1:0]  ss_ll_reg;
    logic [HALF_W-1:0]   ss_lh_reg;

    // Stage B: summed products.
    logic                vb_reg;
    ipow_ctrl_t          ctrl_b_reg;
    logic [POWER_W-1:0]  res_b_reg;
    logic [POWER_W-1:0]  sq_b_reg;

    logic                a_ready;
    logic                a_load;
    logic                b_load;

    logic [HALF_W-1:0]   r_lo;
    logic [HALF_W-1:0]   r_hi;
    logic [HALF_W-1:0]   s_lo;
    logic [HALF_W-1:0]   s_hi;
    logic [POWER_W-1:0]  rs_ll_next;
    logic [HALF_W-1:0]   rs_lh_next;
    logic [HALF_W-1:0]   rs_hl_next;
    logic [POWER_W-1:0]  ss_ll_next;
    logic [HALF_W-1:0]   ss_lh_next;
    logic [HALF_W-1:0]   rs_cross;
    logic [HALF_W-1:0]   ss_cross;
    logic [POWER_W-1:0]  res_b_next;
    logic [POWER_W-1:0]  sq_b_next;

    // A stage takes new data when it is empty or its contents move on.
    assign a_ready  = !vb_reg || out_ready;
    assign in_ready = !va_reg || a_ready;
    assign a_load   = in_valid && in_ready;
    assign b_load   = va_reg && a_ready;

    // Split both operands into 32-bit halves.
    assign r_lo = in_result[HALF_W-1:0];
    assign r_hi = in_result[POWER_W-1:HALF_W];
    assign s_lo = in_square[HALF_W-1:0];
    assign s_hi = in_square[POWER_W-1:HALF_W];

    // Partial products of result*square and square*square.
    assign rs_ll_next = {{HALF_W{1'b0}}, r_lo} * {{HALF_W{1'b0}}, s_lo};
    assign rs_lh_next = r_lo * s_hi;
    assign rs_hl_next = r_hi * s_lo;
    assign ss_ll_next = {{HALF_W{1'b0}}, s_lo} * {{HALF_W{1'b0}}, s_lo};
    assign ss_lh_next = s_lo * s_hi;

    // Sum the partial products; the square's cross term appears twice.
    assign rs_cross   = rs_lh_reg + rs_hl_reg;
    assign ss_cross   = {ss_lh_reg[HALF_W-2:0], 1'b0};
    assign res_b_next = ctrl_a_reg.exponent[BIT] ? (rs_ll_reg + {rs_cross, {HALF_W{1'b0}}})
                                                 : res_a_reg;
    assign sq_b_next  = SQUARE_EN ? (ss_ll_reg + {ss_cross, {HALF_W{1'b0}}}) : POWER_ZERO;

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                va_reg <= in_valid;
            end
            if (a_ready)
            begin
                vb_reg <= va_reg;
            end
        end
    end

    // Stage A data.
    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            ctrl_a_reg <= in_ctrl;
            res_a_reg  <= in_result;
            rs_ll_reg  <= rs_ll_next;
            rs_lh_reg  <= rs_lh_next;
            rs_hl_reg  <= rs_hl_next;
            ss_ll_reg  <= ss_ll_next;
            ss_lh_reg  <= ss_lh_next;
        end
    end

    // Stage B data.
    always_ff @(posedge clk)
    begin
        if (b_load)
        begin
            ctrl_b_reg <= ctrl_a_reg;
            res_b_reg  <= res_b_next;
            sq_b_reg   <= sq_b_next;
        end
    end

    assign out_valid  = vb_reg;
    assign out_ctrl   = ctrl_b_reg;
    assign out_result = res_b_reg;
    assign out_square = sq_b_reg;

endmodule

@@ sv/ipow_out.sv @@
// ============================================================================
// ipow_out: large-exponent rule and result register
// Picks the fixed rule value for large exponents and holds the result
// until the downstream side takes it.
// ============================================================================
module ipow_out (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  ipow_pkg::ipow_ctrl_t        in_ctrl,
    input  logic [ipow_pkg::POWER_W-1:0] in_result,
    output logic                        res_valid,
    input  logic                        res_stall,
    output logic [ipow_pkg::POWER_W-1:0] power
);
    import ipow_pkg::*;

    logic               valid_reg;
    logic [POWER_W-1:0] power_reg;
    logic [POWER_W-1:0] power_next;
    logic [POWER_W-1:0] rule_value;

    assign in_ready = !valid_reg || !res_stall;

    // Large exponent: +1 stays 1, -1 alternates by parity, all else is 0.
    always_comb
    begin
        if (in_ctrl.base_one)
        begin
            rule_value = POWER_ONE;
        end
        else if (in_ctrl.base_mone)
        begin
            rule_value = in_ctrl.exponent[0] ? POWER_MONE : POWER_ONE;
        end
        else
        begin
            rule_value = POWER_ZERO;
        end
    end

    assign power_next = in_ctrl.big ? rule_value : in_result;

    // Result valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Result data.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            power_reg <= power_next;
        end
    end

    assign res_valid = valid_reg;
    assign power     = power_reg;

endmodule

@@ sv/integer_power_by_squaring.sv @@
// ============================================================================
// integer_power_by_squaring: signed 32-bit base to an 8-bit exponent
// Square-and-multiply over six exponent bits in a 13-stage pipeline,
// producing a 64-bit two's complement power that wraps modulo 2^64.
// ============================================================================
//
//   Channel   Handshake              Fields
//   request   req_valid / req_stall  base[31:0] signed, exponent[7:0]
//   result    res_valid / res_stall  power[63:0] signed
//
// One request enters per cycle while req_stall is low; it passes through two
// stages per exponent bit (32x32 partial products, then 64-bit sums) for
// six bits, then through the result register.
// Reset clears only the valid bits. A stalled result holds in place while
// empty stages behind it keep filling; req_stall rises only when every
// stage is occupied.
//
module integer_power_by_squaring (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  logic [ipow_pkg::BASE_W-1:0]  base,
    input  logic [ipow_pkg::EXP_W-1:0]   exponent,
    output logic                         res_valid,
    input  logic                         res_stall,
    output logic [ipow_pkg::POWER_W-1:0] power
);
    import ipow_pkg::*;

    logic                valid_c  [0:STEPS];
    logic                ready_c  [0:STEPS];
    ipow_ctrl_t          ctrl_c   [0:STEPS];
    logic [POWER_W-1:0]  result_c [0:STEPS];
    logic [POWER_W-1:0]  square_c [0:STEPS-1];

    // Request decode: flags for the large-exponent rule, initial operands.
    assign valid_c[0]            = req_valid;
    assign req_stall             = !ready_c[0];
    assign ctrl_c[0].exponent    = exponent;
    assign ctrl_c[0].big         = (exponent >= EXP_LIMIT);
    assign ctrl_c[0].base_one    = (base == BASE_W'(1));
    assign ctrl_c[0].base_mone   = (base == {BASE_W{1'b1}});
    assign result_c[0]           = POWER_ONE;
    assign square_c[0]           = {{(POWER_W-BASE_W){base[BASE_W-1]}}, base};

    // Square-and-multiply chain, least significant exponent bit first.
    genvar i;
    generate
        for (i = 0; i < STEPS; i++)
        begin : g_step
            if (i < STEPS - 1)
            begin : g_mid
                ipow_step #(
                    .BIT       (i),
                    .SQUARE_EN (1'b1)
                ) u_step (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .in_valid   (valid_c[i]),
                    .in_ready   (ready_c[i]),
                    .in_ctrl    (ctrl_c[i]),
                    .in_result  (result_c[i]),
                    .in_square  (square_c[i]),
                    .out_valid  (valid_c[i+1]),
                    .out_ready  (ready_c[i+1]),
                    .out_ctrl   (ctrl_c[i+1]),
                    .out_result (result_c[i+1]),
                    .out_square (square_c[i+1])
                );
            end
            else
            begin : g_last
                // The square after the last bit is never needed.
                ipow_step #(
                    .BIT       (i),
                    .SQUARE_EN (1'b0)
                ) u_step (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .in_valid   (valid_c[i]),
                    .in_ready   (ready_c[i]),
                    .in_ctrl    (ctrl_c[i]),
                    .in_result  (result_c[i]),
                    .in_square  (square_c[i]),
                    .out_valid  (valid_c[i+1]),
                    .out_ready  (ready_c[i+1]),
                    .out_ctrl   (ctrl_c[i+1]),
                    .out_result (result_c[i+1]),
                    .out_square ()
                );
            end
        end
    endgenerate

    // Large-exponent rule and result register.
    ipow_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (valid_c[STEPS]),
        .in_ready  (ready_c[STEPS]),
        .in_ctrl   (ctrl_c[STEPS]),
        .in_result (result_c[STEPS]),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .power     (power)
    );

    // An unstalled result side leaves room for a new request every cycle.
    a_no_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !res_stall |-> !req_stall)
        else $error("request stalled while the result side was free");

    // A zero exponent must leave the running product at one.
    a_zero_exp: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_c[STEPS] && ctrl_c[STEPS].exponent == '0) |-> (result_c[STEPS] == POWER_ONE))
        else $error("zero exponent produced a product other than one");

    // Base +1 below the limit keeps every product at one.
    a_base_one: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_c[STEPS] && !ctrl_c[STEPS].big && ctrl_c[STEPS].base_one)
        |-> (result_c[STEPS] == POWER_ONE))
        else $error("base one produced a product other than one");

    // Base -1 below the limit alternates sign with exponent parity.
    a_base_mone: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_c[STEPS] && !ctrl_c[STEPS].big && ctrl_c[STEPS].base_mone)
        |-> (result_c[STEPS] == (ctrl_c[STEPS].exponent[0] ? POWER_MONE : POWER_ONE)))
        else $error("base minus one produced a wrong sign");

endmodule
